>>> design/mcr_pkg.sv
// Shared types and constants for the midpoint circle rasterizer.
// No dependencies; imported by every module of the block.
`default_nettype none

package mcr_pkg;

  localparam int CoordBits  = 15;
  localparam int RadiusBits = CoordBits - 1;
  localparam int OutBits    = CoordBits + 1;
  localparam int ErrBits    = 17;
  localparam int WideBits   = CoordBits + ErrBits;

  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_STEP   = 1'b1;
  localparam logic KIND_POINT = 1'b0;
  localparam logic KIND_SPAN  = 1'b1;

  // Result slots of one step, in emission order.
  typedef enum logic [3:0] {
    SLOT_PT0,
    SLOT_PT1,
    SLOT_PT2,
    SLOT_PT3,
    SLOT_PT4,
    SLOT_PT5,
    SLOT_PT6,
    SLOT_PT7,
    SLOT_SPAN0,
    SLOT_SPAN1,
    SLOT_SPAN2,
    SLOT_SPAN3
  } slot_t;

  // Octant position handed from the core to the emitter on a productive step.
  typedef struct packed {
    logic signed [CoordBits-1:0] cx;
    logic signed [CoordBits-1:0] cy;
    logic signed [CoordBits-1:0] x;
    logic signed [CoordBits-1:0] y;
    logic                        fill;
    logic                        fin;
  } snap_t;

endpackage

`default_nettype wire

>>> design/mcr_octant_core.sv
// Circle state and midpoint advance: takes start and step beats.
// Depends on mcr_pkg; feeds a snapshot to mcr_emitter.
`default_nettype none

module mcr_octant_core (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_fire,
  input  wire                             in_command,
  input  wire signed [mcr_pkg::CoordBits-1:0]  in_center_x,
  input  wire signed [mcr_pkg::CoordBits-1:0]  in_center_y,
  input  wire        [mcr_pkg::RadiusBits-1:0] in_radius,
  input  wire                             in_fill,
  output logic                            emit,
  output mcr_pkg::snap_t                  snap
);
  import mcr_pkg::*;

  logic signed [CoordBits-1:0] x_r, y_r, cx_r, cy_r;
  logic signed [ErrBits-1:0]   err_r;
  logic                        fill_r, active_r;

  logic signed [CoordBits-1:0] x_nxt, y_nxt;
  logic signed [ErrBits-1:0]   err_nxt;
  logic [WideBits-1:0]         e1_w, d_w, e2_w;
  logic signed [ErrBits-1:0]   e1;
  logic                        x_ge_y, step_x, fin;

  always_comb begin
    x_ge_y = (x_r >= y_r);
    y_nxt  = y_r + 1'b1;
    // err + 1 + 2*(y+1), kept modulo 2^ErrBits
    e1_w   = WideBits'(err_r) + (WideBits'(y_r) << 1) + WideBits'(3);
    e1     = e1_w[ErrBits-1:0];
    d_w    = WideBits'(e1) - WideBits'(x_r);
    step_x = !d_w[WideBits-1];
    // e1 + 1 - 2*(x-1)
    e2_w   = WideBits'(e1) + WideBits'(3) - (WideBits'(x_r) << 1);
    if (step_x) begin
      x_nxt   = x_r - 1'b1;
      err_nxt = e2_w[ErrBits-1:0];
    end else begin
      x_nxt   = x_r;
      err_nxt = e1;
    end
    fin = (x_nxt < y_nxt);
  end

  always_comb begin
    emit      = in_fire && (in_command == CMD_STEP) && active_r && x_ge_y;
    snap.cx   = cx_r;
    snap.cy   = cy_r;
    snap.x    = x_r;
    snap.y    = y_r;
    snap.fill = fill_r;
    snap.fin  = fin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r      <= '0;
      y_r      <= '0;
      err_r    <= '0;
      cx_r     <= '0;
      cy_r     <= '0;
      fill_r   <= 1'b0;
      active_r <= 1'b0;
    end else if (in_fire) begin
      if (in_command == CMD_START) begin
        cx_r     <= in_center_x;
        cy_r     <= in_center_y;
        x_r      <= $signed({1'b0, in_radius});
        y_r      <= '0;
        err_r    <= '0;
        fill_r   <= in_fill;
        active_r <= 1'b1;
      end else if (active_r) begin
        if (!x_ge_y) begin
          active_r <= 1'b0;
        end else begin
          x_r   <= x_nxt;
          y_r   <= y_nxt;
          err_r <= err_nxt;
          if (fin) begin
            active_r <= 1'b0;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> design/mcr_emitter.sv
// Result sequencer and output register: walks the points and spans of one step.
// Depends on mcr_pkg; loaded from mcr_octant_core.
`default_nettype none

module mcr_emitter (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              emit,
  input  wire mcr_pkg::snap_t              snap,
  output logic                             free,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic                             out_kind,
  output logic signed [mcr_pkg::OutBits-1:0] out_start_x,
  output logic signed [mcr_pkg::OutBits-1:0] out_start_y,
  output logic signed [mcr_pkg::OutBits-1:0] out_end_x,
  output logic signed [mcr_pkg::OutBits-1:0] out_end_y,
  output logic                             out_last,
  output logic                             out_done_res
);
  import mcr_pkg::*;

  logic  busy_r, out_valid_r;
  slot_t slot_r;
  snap_t snap_r;

  logic                      kind_r, last_r, done_r;
  logic signed [OutBits-1:0] sx_r, sy_r, ex_r, ey_r;

  logic                      load_slot, is_last, kind_nxt;
  logic signed [OutBits-1:0] sx_nxt, sy_nxt, ex_nxt, ey_nxt;
  logic signed [OutBits-1:0] cx_px, cx_mx, cx_py, cx_my, cy_py, cy_my, cy_px, cy_mx;

  always_comb begin
    load_slot = busy_r && (!out_valid_r || out_ready);
    is_last   = (slot_r == SLOT_SPAN3) || ((slot_r == SLOT_PT7) && !snap_r.fill);
    free      = !busy_r || (load_slot && is_last);

    cx_px = OutBits'(snap_r.cx) + OutBits'(snap_r.x);
    cx_mx = OutBits'(snap_r.cx) - OutBits'(snap_r.x);
    cx_py = OutBits'(snap_r.cx) + OutBits'(snap_r.y);
    cx_my = OutBits'(snap_r.cx) - OutBits'(snap_r.y);
    cy_py = OutBits'(snap_r.cy) + OutBits'(snap_r.y);
    cy_my = OutBits'(snap_r.cy) - OutBits'(snap_r.y);
    cy_px = OutBits'(snap_r.cy) + OutBits'(snap_r.x);
    cy_mx = OutBits'(snap_r.cy) - OutBits'(snap_r.x);

    kind_nxt = KIND_POINT;
    sx_nxt   = cx_px;
    sy_nxt   = cy_py;
    case (slot_r)
      SLOT_PT0: begin sx_nxt = cx_px; sy_nxt = cy_py; end
      SLOT_PT1: begin sx_nxt = cx_py; sy_nxt = cy_px; end
      SLOT_PT2: begin sx_nxt = cx_my; sy_nxt = cy_px; end
      SLOT_PT3: begin sx_nxt = cx_mx; sy_nxt = cy_py; end
      SLOT_PT4: begin sx_nxt = cx_mx; sy_nxt = cy_my; end
      SLOT_PT5: begin sx_nxt = cx_my; sy_nxt = cy_mx; end
      SLOT_PT6: begin sx_nxt = cx_py; sy_nxt = cy_mx; end
      SLOT_PT7: begin sx_nxt = cx_px; sy_nxt = cy_my; end
      SLOT_SPAN0: begin kind_nxt = KIND_SPAN; sx_nxt = cx_mx; sy_nxt = cy_py; end
      SLOT_SPAN1: begin kind_nxt = KIND_SPAN; sx_nxt = cx_mx; sy_nxt = cy_my; end
      SLOT_SPAN2: begin kind_nxt = KIND_SPAN; sx_nxt = cx_my; sy_nxt = cy_px; end
      SLOT_SPAN3: begin kind_nxt = KIND_SPAN; sx_nxt = cx_my; sy_nxt = cy_mx; end
      default: begin kind_nxt = KIND_POINT; sx_nxt = cx_px; sy_nxt = cy_py; end
    endcase
    // spans run left to right: mirror the left x; points end where they start
    ex_nxt = (kind_nxt == KIND_SPAN) ? -sx_nxt + (OutBits'(snap_r.cx) <<< 1) : sx_nxt;
    ey_nxt = sy_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      slot_r      <= SLOT_PT0;
      out_valid_r <= 1'b0;
    end else begin
      if (load_slot) begin
        out_valid_r <= 1'b1;
        slot_r      <= slot_t'(slot_r + 1'b1);
        if (is_last) begin
          busy_r <= 1'b0;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (emit) begin
        busy_r <= 1'b1;
        slot_r <= SLOT_PT0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      snap_r <= snap;
    end
    if (load_slot) begin
      kind_r <= kind_nxt;
      sx_r   <= sx_nxt;
      sy_r   <= sy_nxt;
      ex_r   <= ex_nxt;
      ey_r   <= ey_nxt;
      last_r <= is_last;
      done_r <= snap_r.fin;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = kind_r;
  assign out_start_x  = sx_r;
  assign out_start_y  = sy_r;
  assign out_end_x    = ex_r;
  assign out_end_y    = ey_r;
  assign out_last     = last_r;
  assign out_done_res = done_r;

endmodule

`default_nettype wire

>>> design/midpoint_circle_rasterizer.sv
// Top level of the midpoint circle rasterizer.
// Depends on mcr_pkg, mcr_octant_core and mcr_emitter.
//
// Input channel (in_valid/in_ready): a start beat (command 0) loads center,
// radius and fill flag and gives no result. A step beat (command 1) on a
// running circle emits the eight octant points of the current position and,
// with fill set, four horizontal spans, then advances the octant. A step on
// an idle or finished circle gives nothing.
// Output channel (out_valid/out_ready): one result per beat; out_last marks
// the final result of a step, out_done_res is set on every result of the
// step that finishes the circle.
// The step beat loads the snapshot register; the first result is then loaded
// into the output register once that register can take it.
// A step gives eight results, twelve with fill, which the emitter walks one
// result per cycle through its output register while the receiver does not
// stall; the next beat is taken in the cycle the last result is loaded. Start
// beats and steps without results do not hold in_ready low.
// Reset (rst_n low, synchronous) idles the block and clears the circle state.
// A receiver stall holds the output register and the result walk; in_ready
// stays low from a step beat with results until the last result of that step is loaded.
`default_nettype none

module midpoint_circle_rasterizer (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire                               in_command,
  input  wire signed [mcr_pkg::CoordBits-1:0]  in_center_x,
  input  wire signed [mcr_pkg::CoordBits-1:0]  in_center_y,
  input  wire        [mcr_pkg::RadiusBits-1:0] in_radius,
  input  wire                               in_fill,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic                              out_kind,
  output logic signed [mcr_pkg::OutBits-1:0]   out_start_x,
  output logic signed [mcr_pkg::OutBits-1:0]   out_start_y,
  output logic signed [mcr_pkg::OutBits-1:0]   out_end_x,
  output logic signed [mcr_pkg::OutBits-1:0]   out_end_y,
  output logic                              out_last,
  output logic                              out_done_res
);
  import mcr_pkg::*;

  logic  free, in_fire, emit;
  snap_t snap;

  assign in_ready = free;
  assign in_fire  = in_valid && free;

  mcr_octant_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .in_command  (in_command),
    .in_center_x (in_center_x),
    .in_center_y (in_center_y),
    .in_radius   (in_radius),
    .in_fill     (in_fill),
    .emit        (emit),
    .snap        (snap)
  );

  mcr_emitter u_emit (
    .clk          (clk),
    .rst_n        (rst_n),
    .emit         (emit),
    .snap         (snap),
    .free         (free),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .out_start_x  (out_start_x),
    .out_start_y  (out_start_y),
    .out_end_x    (out_end_x),
    .out_end_y    (out_end_y),
    .out_last     (out_last),
    .out_done_res (out_done_res)
  );

endmodule

`default_nettype wire
